// ----- hdl/crmt_pkg.sv -----
package crmt_pkg;

  // Protocol constants
  localparam logic [31:0] MAGIC_VALUE  = 32'h31304356;
  localparam logic [10:0] VOICE_HEADER = 11'd7;
  localparam logic [7:0]  PKT_JOIN     = 8'd1;
  localparam logic [7:0]  PKT_VOICE    = 8'd2;
  localparam logic [7:0]  PKT_LEAVE    = 8'd4;

  // Configuration register indexes
  localparam logic [0:0] REG_TIMEOUT     = 1'b0;
  localparam logic [0:0] REG_FIRST_TALKER = 1'b1;

  // Result event codes
  localparam logic [3:0] EV_IGNORED   = 4'd0;
  localparam logic [3:0] EV_JOINED    = 4'd1;
  localparam logic [3:0] EV_REFRESHED = 4'd2;
  localparam logic [3:0] EV_FULL      = 4'd3;
  localparam logic [3:0] EV_LEFT      = 4'd4;
  localparam logic [3:0] EV_FORWARD   = 4'd5;
  localparam logic [3:0] EV_NO_RCPT   = 4'd6;
  localparam logic [3:0] EV_EVICTED   = 4'd7;
  localparam logic [3:0] EV_TICK_DONE = 4'd8;

  // One table entry as stored in the memory
  typedef struct packed {
    logic [47:0] address;
    logic [15:0] talker;
    logic [7:0]  channel;
    logic [31:0] last_seen;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [3:0]  event_res;
    logic [47:0] dest_address;
    logic [15:0] talker_id;
    logic [10:0] out_length;
    logic        last;
  } result_t;

endpackage

// ----- hdl/channel_relay_membership_table_unit.sv -----
// Voice relay membership table. Each accepted item (a parsed datagram header or a
// time tick) is handled by a sequencer around one synchronous entry memory with a
// single read and a single write port whose read data is registered. A join, leave or
// voice item first scans the table for the sender, one entry per cycle; a leave then
// compacts the following entries, a voice item walks the table a second time to send
// one forward per other client on the sender's channel, and a tick walks the table
// once, evicting and compacting in the same pass. Each result is staged for one step
// before it moves to the output register, so that the final result of an item can be
// marked; a walk stalls only while both the staging and the output register are full.
// A new item is taken once the output register is empty. Configuration writes belong
// between items, while no item is in work.
module channel_relay_membership_table_unit
  import crmt_pkg::*;
#(
  parameter int MAX_CLIENTS = 64,
  parameter int FRAME_BYTES = 320
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [47:0] source_address,
  input  logic [10:0] datagram_length,
  input  logic [31:0] magic_word,
  input  logic [7:0]  packet_type,
  input  logic [7:0]  channel_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_res,
  output logic [47:0] dest_address,
  output logic [15:0] talker_id,
  output logic [10:0] out_length,
  output logic        last
);

  localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW = $clog2(MAX_CLIENTS + 1);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_CLIENTS);
  localparam logic [10:0] VOICE_MAX = 11'(7 + FRAME_BYTES);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FIND  = 8'b00000010,
    S_DECIDE = 8'b00000100,
    S_LEAVE = 8'b00001000,
    S_FWD   = 8'b00010000,
    S_TICK  = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_FINAL = 8'b10000000
  } state_t;

  state_t state;

  // Entry memory
  entry_t mem [MAX_CLIENTS];
  entry_t rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Architectural state
  logic [CW-1:0] client_count;
  logic [15:0]   next_talker;
  logic [31:0]   current_time;
  logic [31:0]   timeout_ticks;

  // Item registers
  logic        it_tick;
  logic [47:0] it_src;
  logic [10:0] it_len;
  logic [7:0]  it_type, it_chan;

  // Walk control: rd_idx is the next index to read, pend marks rd_data valid for cur
  logic [CW-1:0] rd_idx, cur, wpos;
  logic          pend;
  logic          found;
  logic [AW-1:0] found_idx;
  entry_t        sender;
  logic          any_out;

  // Output register
  result_t obuf;
  logic    obuf_valid;
  logic    obuf_free;
  assign obuf_free = !obuf_valid || out_ready;

  assign out_valid    = obuf_valid;
  assign event_res    = obuf.event_res;
  assign dest_address = obuf.dest_address;
  assign talker_id    = obuf.talker_id;
  assign out_length   = obuf.out_length;
  assign last         = obuf.last;

  assign in_ready = (state == S_IDLE) && !obuf_valid;

  // Staged result; it moves to the output register when the next one arrives, or from S_FINAL
  result_t pres;

  logic hit, stale, fwd_hit;
  assign hit     = pend && (rd_data.address == it_src);
  assign stale   = pend && ((current_time - rd_data.last_seen) > timeout_ticks);
  assign fwd_hit = pend && (rd_data.talker != sender.talker)
                   && (rd_data.channel == sender.channel);

  logic more;
  assign more = (rd_idx < client_count);

  // A walk waits when a new result meets a full staging and output register
  logic fwd_stall, tick_stall, obuf_load;
  assign fwd_stall  = (state == S_FWD) && fwd_hit && any_out && !obuf_free;
  assign tick_stall = (state == S_TICK) && stale && any_out && !obuf_free;
  assign obuf_load  = ((state == S_FWD) && fwd_hit && any_out && obuf_free)
                      || ((state == S_TICK) && stale && any_out && obuf_free)
                      || ((state == S_FINAL) && obuf_free);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = rd_idx[AW-1:0];
    wr_en = 1'b0;
    wr_addr = wpos[AW-1:0];
    wr_data = rd_data;
    case (state)
      S_FIND, S_LEAVE: begin
        rd_en = more;
      end
      S_FWD: begin
        rd_en = more && !fwd_stall;
      end
      S_TICK: begin
        rd_en = more && !tick_stall;
      end
      default: begin
      end
    endcase
    if (state == S_LEAVE && pend) begin
      wr_en = 1'b1;
    end
    if (state == S_TICK && pend && !stale) begin
      wr_en = 1'b1;
    end
    // Write back the sender after a join or refresh, and after a voice walk
    if (state == S_DECIDE || (state == S_EMIT && !it_tick)) begin
      wr_addr = found_idx;
      wr_data = sender;
    end
    if (state == S_DECIDE && it_type == 8'd0 && it_len == 11'd0 && found) begin
      wr_en = 1'b1;
    end
    if (state == S_EMIT && !it_tick) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      client_count <= '0;
      next_talker <= 16'd0;
      current_time <= 32'd0;
      timeout_ticks <= 32'd15000;
      obuf_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      if (obuf_load) begin
        obuf <= pres;
        obuf_valid <= 1'b1;
      end else if (obuf_valid && out_ready) begin
        obuf_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_ticks <= cfg_data;
          REG_FIRST_TALKER: next_talker <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            it_tick <= req_type;
            it_src <= source_address;
            it_len <= datagram_length;
            it_type <= packet_type;
            it_chan <= channel_byte;
            rd_idx <= '0;
            wpos <= '0;
            cur <= '0;
            pend <= 1'b0;
            found <= 1'b0;
            any_out <= 1'b0;
            if (req_type) begin
              state <= S_TICK;
            end else if (datagram_length < 11'd5 || magic_word != MAGIC_VALUE) begin
              pres <= '{EV_IGNORED, source_address, 16'd0, 11'd0, 1'b1};
              state <= S_FINAL;
            end else begin
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          // One entry per cycle; stop at the first address match
          if (hit) begin
            found <= 1'b1;
            found_idx <= cur[AW-1:0];
            sender <= rd_data;
            pend <= 1'b0;
            state <= S_DECIDE;
          end else if (more) begin
            pend <= 1'b1;
            cur <= rd_idx;
            rd_idx <= rd_idx + 1'b1;
          end else begin
            pend <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_FINAL;
          if (it_type == PKT_JOIN && it_len >= 11'd6) begin
            if (!found) begin
              if (client_count >= LIMIT) begin
                pres <= '{EV_FULL, it_src, 16'd0, 11'd0, 1'b1};
              end else begin
                found_idx <= client_count[AW-1:0];
                sender <= '{it_src, next_talker, it_chan, current_time};
                next_talker <= next_talker + 16'd1;
                client_count <= client_count + 1'b1;
                found <= 1'b1;
                pres <= '{EV_JOINED, it_src, next_talker, 11'd0, 1'b1};
                state <= S_DECIDE;
                it_type <= 8'd0;
                it_len <= 11'd0;
              end
            end else begin
              sender.channel <= it_chan;
              sender.last_seen <= current_time;
              pres <= '{EV_REFRESHED, it_src, sender.talker, 11'd0, 1'b1};
              it_type <= 8'd0;
              it_len <= 11'd0;
              state <= S_DECIDE;
            end
          end else if (it_type == 8'd0 && it_len == 11'd0 && found) begin
            // Second pass after a join or refresh: the sender is written back to memory this cycle
            state <= S_FINAL;
          end else if (it_type == PKT_LEAVE && found) begin
            pres <= '{EV_LEFT, it_src, sender.talker, 11'd0, 1'b1};
            wpos <= CW'(found_idx);
            rd_idx <= CW'(found_idx) + 1'b1;
            pend <= 1'b0;
            state <= S_LEAVE;
          end else if (it_type == PKT_VOICE && it_len > VOICE_HEADER && it_len <= VOICE_MAX
                       && found) begin
            sender.last_seen <= current_time;
            rd_idx <= '0;
            pend <= 1'b0;
            state <= S_FWD;
          end else begin
            pres <= '{EV_IGNORED, it_src, 16'd0, 11'd0, 1'b1};
          end
        end
        S_LEAVE: begin
          // Move each later entry up by one
          if (pend) begin
            wpos <= wpos + 1'b1;
          end
          if (more) begin
            pend <= 1'b1;
            rd_idx <= rd_idx + 1'b1;
          end else begin
            pend <= 1'b0;
            client_count <= client_count - 1'b1;
            state <= S_FINAL;
          end
        end
        S_FWD: begin
          // Stage each forward; the one staged before it moves to the output register
          if (!fwd_stall) begin
            if (fwd_hit) begin
              pres <= '{EV_FORWARD, rd_data.address, sender.talker, it_len + 11'd2,
                        1'b0};
              any_out <= 1'b1;
            end
            if (more) begin
              pend <= 1'b1;
              rd_idx <= rd_idx + 1'b1;
            end else begin
              pend <= 1'b0;
              state <= S_EMIT;
            end
          end
        end
        S_TICK: begin
          // Stage each eviction and compact the entries that stay
          if (!tick_stall) begin
            if (stale) begin
              pres <= '{EV_EVICTED, rd_data.address, rd_data.talker, 11'd0, 1'b0};
              any_out <= 1'b1;
            end else if (pend) begin
              wpos <= wpos + 1'b1;
            end
            if (more) begin
              pend <= 1'b1;
              rd_idx <= rd_idx + 1'b1;
            end else begin
              pend <= 1'b0;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // Mark the last forward or eviction; if none, give a no-recipient or tick-done result
          if (it_tick) begin
            client_count <= wpos;
            current_time <= current_time + 32'd1;
            if (any_out) begin
              pres.last <= 1'b1;
            end else begin
              pres <= '{EV_TICK_DONE, 48'd0, 16'd0, 11'd0, 1'b1};
            end
          end else begin
            if (any_out) begin
              pres.last <= 1'b1;
            end else begin
              pres <= '{EV_NO_RCPT, it_src, sender.talker, 11'd0, 1'b1};
            end
          end
          state <= S_FINAL;
        end
        S_FINAL: begin
          // The staged final result moves out once the output register frees
          if (obuf_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
